FILE: hdl/run_prediction_sample_decoder_unit_macros.svh
// assertion macros for the run prediction sample decoder
`ifndef RUN_PREDICTION_SAMPLE_DECODER_UNIT_MACROS_SVH
`define RUN_PREDICTION_SAMPLE_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// condition and consequence in the same cycle
`define RPSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequence in the cycle after the condition
`define RPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPSD_ASSERT_NOW(lbl, ante, cons, msg)
`define RPSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/rpsd_pkg.sv
// shared types, constants and functions of the run prediction sample decoder
`default_nettype none
package rpsd_pkg;

    localparam int RUN_FIELD_BITS = 5;
    localparam int RUN_LEN_W      = RUN_FIELD_BITS + 1;
    localparam int SAMPLE_W       = 16;
    localparam int COUNT_W        = 32;
    localparam int BYTE_BITS      = 8;
    localparam int BIT_CNT_W      = $clog2(BYTE_BITS + 1);
    localparam int TAG_BITS       = 2;
    localparam int FILL_W         = $clog2(SAMPLE_W);
    localparam int HDR_IDX_W      = 2;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    localparam logic [TAG_BITS-1:0] TAG_SYNC     = 2'd0;
    localparam logic [TAG_BITS-1:0] TAG_PREDICT  = 2'd1;
    localparam logic [TAG_BITS-1:0] TAG_RAW      = 2'd2;
    localparam logic [TAG_BITS-1:0] TAG_VELOCITY = 2'd3;

    typedef enum logic [1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_FINISHED = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CAPACITY  = 3'd1,
        ERR_NO_SYNC   = 3'd2,
        ERR_RUN_PAST  = 3'd3,
        ERR_TRUNCATED = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_TAG      = 4'd1,
        PH_SYNC_POS = 4'd2,
        PH_SYNC_VEL = 4'd3,
        PH_VEL      = 4'd4,
        PH_RUNLEN   = 4'd5,
        PH_CORR     = 4'd6,
        PH_RAW      = 4'd7,
        PH_DRAIN    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_HDRCHK = 3'd1,
        S_BITS   = 3'd2,
        S_RUN    = 3'd3,
        S_CORR   = 3'd4,
        S_FIN    = 3'd5,
        S_END    = 3'd6,
        S_FLUSH  = 3'd7
    } st_t;

    typedef struct packed {
        kind_t                kind;
        logic [SAMPLE_W-1:0]  sample;
        logic [COUNT_W-1:0]   produced;
        err_t                 error_code;
    } res_t;

    typedef struct packed {
        logic push;
        logic flush;
    } rbuf_ctl_t;

    typedef struct packed {
        logic can_push;
        logic can_flush;
        logic pend_valid;
    } rbuf_sts_t;

    typedef struct packed {
        logic load;
        logic shift;
    } bsrc_ctl_t;

    typedef struct packed {
        logic bit_val;
        logic last;
        logic empty;
    } bsrc_sts_t;

    function automatic logic [SAMPLE_W-1:0] unzig16(input logic [SAMPLE_W-1:0] u);
        return (u >> 1) ^ {SAMPLE_W{u[0]}};
    endfunction

    function automatic logic [SAMPLE_W-1:0] sat_add16(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (s[SAMPLE_W] != s[SAMPLE_W-1])
        begin
            return s[SAMPLE_W] ? SAT_MIN : SAT_MAX;
        end
        return s[SAMPLE_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rpsd_bit_source.sv
// byte shift register that hands out one bit per cycle while shift is asserted, lsb first
`default_nettype none
module rpsd_bit_source (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rpsd_pkg::bsrc_ctl_t   ctl,
    input  wire logic [7:0]            load_byte,
    output rpsd_pkg::bsrc_sts_t        sts
);

    logic [rpsd_pkg::BYTE_BITS-1:0] byte_reg, byte_next;
    logic [rpsd_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        if (ctl.load)
        begin
            byte_next = load_byte;
            cnt_next  = '0;
        end
        else if (ctl.shift)
        begin
            byte_next = byte_reg >> 1;
            cnt_next  = cnt_reg + rpsd_pkg::BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= rpsd_pkg::BIT_CNT_W'(rpsd_pkg::BYTE_BITS);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign sts.bit_val = byte_reg[0];
    assign sts.last    = (cnt_reg == rpsd_pkg::BIT_CNT_W'(rpsd_pkg::BYTE_BITS - 1));
    assign sts.empty   = (cnt_reg == rpsd_pkg::BIT_CNT_W'(rpsd_pkg::BYTE_BITS));

endmodule
`default_nettype wire

FILE: hdl/rpsd_result_buffer.sv
// holding slot plus output register, marks the last word of each byte
`default_nettype none
`include "run_prediction_sample_decoder_unit_macros.svh"
module rpsd_result_buffer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rpsd_pkg::rbuf_ctl_t   ctl,
    input  wire rpsd_pkg::res_t        push_data,
    output rpsd_pkg::rbuf_sts_t        sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 kind,
    output logic signed [15:0]         sample,
    output logic [31:0]                produced,
    output logic [2:0]                 error_code,
    output logic                       final_res
);

    logic           pend_valid_reg, pend_valid_next;
    logic           out_valid_reg, out_valid_next;
    rpsd_pkg::res_t pend_res_reg, pend_res_next;
    rpsd_pkg::res_t out_res_reg, out_res_next;
    logic           out_final_reg, out_final_next;
    logic           can_move;
    logic           move;

    assign can_move = !out_valid_reg || out_ready;
    assign move     = pend_valid_reg && (ctl.push || ctl.flush);

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_res_next    = out_res_reg;
        out_final_next  = out_final_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (move)
        begin
            // a word pushed behind the held one means the held one is not last
            out_valid_next = 1'b1;
            out_res_next   = pend_res_reg;
            out_final_next = !ctl.push;
        end
        if (ctl.push)
        begin
            pend_valid_next = 1'b1;
            pend_res_next   = push_data;
        end
        else if (ctl.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_res_reg  <= pend_res_next;
        out_res_reg   <= out_res_next;
        out_final_reg <= out_final_next;
    end

    assign sts.can_push   = !pend_valid_reg || can_move;
    assign sts.can_flush  = can_move;
    assign sts.pend_valid = pend_valid_reg;

    assign out_valid  = out_valid_reg;
    assign kind       = out_res_reg.kind;
    assign sample     = $signed(out_res_reg.sample);
    assign produced   = out_res_reg.produced;
    assign error_code = out_res_reg.error_code;
    assign final_res  = out_final_reg;

    `RPSD_ASSERT_NOW(a_push_room, ctl.push && pend_valid_reg, can_move, "push with no room")
    `RPSD_ASSERT_NOW(a_push_flush_excl, ctl.push, !ctl.flush, "push and flush together")
    `RPSD_ASSERT_NEXT(a_flush_empties, ctl.flush && can_move, !pend_valid_reg,
                      "flush left a held word")

endmodule
`default_nettype wire

FILE: hdl/run_prediction_sample_decoder_unit.sv
// top level of the run prediction sample decoder: control sequencer and bit datapath
`default_nettype none
`include "run_prediction_sample_decoder_unit_macros.svh"
// Decodes a packet of compressed bytes into signed 16-bit samples. A packet opens
// with a 4-byte little-endian sample count, followed by an lsb-first bit stream of
// tagged tokens (sync, velocity, predict run, raw run). Each output word carries a
// kind (sample, finished, error), the sample, the running sample count, an error
// code and a flag on the last word caused by the input byte. Bytes are taken one
// at a time: from accept to the next ready a header byte passes the end and flush
// states, the fourth one the count check before them, a stream byte a shift step
// for each bit before them, as the byte shift register feeds the field shifter one
// bit per cycle. A predict run adds a run step for each predicted sample and a
// correction step. A finished word after a sync or raw sample takes a step of its
// own and drops the byte's remaining bits, as does a bit stream error. Steps stall
// while slot and output register are full and out_ready is low. The input side is
// ready again while the last word of a byte still sits in the output register.
module run_prediction_sample_decoder_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration: max_samples
    input  wire logic          cfg_wen,
    input  wire logic [31:0]   cfg_wdata,
    // input words
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_input,
    // output words
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         kind,
    output logic signed [15:0] sample,
    output logic [31:0]        produced,
    output logic [2:0]         error_code,
    output logic               final_res
);

    localparam int SW = rpsd_pkg::SAMPLE_W;
    localparam int CW = rpsd_pkg::COUNT_W;
    localparam int RW = rpsd_pkg::RUN_LEN_W;
    localparam int FW = rpsd_pkg::FILL_W;
    localparam int RB = rpsd_pkg::RUN_FIELD_BITS;
    localparam int TB = rpsd_pkg::TAG_BITS;
    localparam int HW = rpsd_pkg::HDR_IDX_W;

    // sequencer and decoding state
    rpsd_pkg::st_t          st_reg, st_next;
    rpsd_pkg::phase_t       phase_reg, phase_next;
    logic [HW-1:0]          hdr_idx_reg, hdr_idx_next;
    logic [CW-1:0]          target_reg, target_next;
    logic [CW-1:0]          done_reg, done_next;
    logic [SW-1:0]          fbuf_reg, fbuf_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [SW-1:0]          pos_reg, pos_next;
    logic [SW-1:0]          vel_reg, vel_next;
    logic                   synced_reg, synced_next;
    logic [RW-1:0]          run_reg, run_next;
    logic [TB-1:0]          ptag_reg, ptag_next;
    logic [SW-1:0]          corr_reg, corr_next;
    logic                   eoi_reg, eoi_next;
    logic [CW-1:0]          max_reg;

    // sub-module links
    rpsd_pkg::bsrc_ctl_t    bs_ctl;
    rpsd_pkg::bsrc_sts_t    bs_sts;
    rpsd_pkg::rbuf_ctl_t    rb_ctl;
    rpsd_pkg::rbuf_sts_t    rb_sts;
    rpsd_pkg::res_t         push_res;

    // decode terms
    logic                   accept;
    logic                   adv;
    logic [SW-1:0]          fshift;
    logic [FW-1:0]          need_m1;
    logic                   fdone;
    logic [TB-1:0]          tagv;
    logic [RW-1:0]          run_len_v;
    logic [SW-1:0]          zz;
    logic [CW-1:0]          done_inc;
    logic                   match_inc;
    logic                   run_over;
    logic [SW-1:0]          sat_pv;
    logic [SW-1:0]          sat_pc;

    rpsd_bit_source u_bits (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (bs_ctl),
        .load_byte (data_byte),
        .sts       (bs_sts)
    );

    rpsd_result_buffer u_rbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rb_ctl),
        .push_data  (push_res),
        .sts        (rb_sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .sample     (sample),
        .produced   (produced),
        .error_code (error_code),
        .final_res  (final_res)
    );

    assign in_ready = (st_reg == rpsd_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    // every working step may emit a word, so it waits for room
    assign adv      = rb_sts.can_push;

    // field shifter terms: bits enter at the top, a full field ends up in the top bits
    always_comb
    begin
        fshift = {bs_sts.bit_val, fbuf_reg[SW-1:1]};
        unique case (phase_reg)
            rpsd_pkg::PH_TAG:    need_m1 = FW'(TB - 1);
            rpsd_pkg::PH_RUNLEN: need_m1 = FW'(RB - 1);
            default:             need_m1 = FW'(SW - 1);
        endcase
        fdone     = (fill_reg == need_m1);
        tagv      = fshift[SW-1 -: TB];
        run_len_v = {1'b0, fshift[SW-1 -: RB]} + RW'(1);
        zz        = rpsd_pkg::unzig16(fshift);
        done_inc  = done_reg + CW'(1);
        match_inc = (done_inc == target_reg);
        run_over  = (({1'b0, done_reg} + (CW+1)'(run_len_v)) > {1'b0, target_reg});
        sat_pv    = rpsd_pkg::sat_add16(pos_reg, vel_reg);
        sat_pc    = rpsd_pkg::sat_add16(pos_reg, corr_reg);
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            rpsd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (phase_reg == rpsd_pkg::PH_HEADER)
                        st_next = (hdr_idx_reg == HW'(3)) ? rpsd_pkg::S_HDRCHK
                                                           : rpsd_pkg::S_END;
                    else if (phase_reg == rpsd_pkg::PH_DRAIN)
                        st_next = rpsd_pkg::S_END;
                    else
                        st_next = rpsd_pkg::S_BITS;
                end
            end
            rpsd_pkg::S_HDRCHK:
            begin
                if (adv)
                    st_next = rpsd_pkg::S_END;
            end
            rpsd_pkg::S_BITS:
            begin
                if (adv)
                begin
                    st_next = bs_sts.last ? rpsd_pkg::S_END : rpsd_pkg::S_BITS;
                    if (fdone)
                    begin
                        unique case (phase_reg)
                            rpsd_pkg::PH_TAG:
                                if (tagv != rpsd_pkg::TAG_SYNC && !synced_reg)
                                    st_next = rpsd_pkg::S_END;
                            rpsd_pkg::PH_SYNC_VEL, rpsd_pkg::PH_RAW:
                                if (match_inc)
                                    st_next = rpsd_pkg::S_FIN;
                            rpsd_pkg::PH_RUNLEN:
                                if (run_over)
                                    st_next = rpsd_pkg::S_END;
                            rpsd_pkg::PH_CORR:
                                st_next = rpsd_pkg::S_RUN;
                            default:
                                st_next = st_next;
                        endcase
                    end
                end
            end
            rpsd_pkg::S_RUN:
            begin
                if (adv && run_reg == RW'(1))
                    st_next = rpsd_pkg::S_CORR;
            end
            rpsd_pkg::S_CORR:
            begin
                if (adv)
                begin
                    priority if (done_reg == target_reg || bs_sts.empty)
                        st_next = rpsd_pkg::S_END;
                    else
                        st_next = rpsd_pkg::S_BITS;
                end
            end
            rpsd_pkg::S_FIN:
            begin
                if (adv)
                    st_next = rpsd_pkg::S_END;
            end
            rpsd_pkg::S_END:
            begin
                if (adv)
                    st_next = rpsd_pkg::S_FLUSH;
            end
            rpsd_pkg::S_FLUSH:
            begin
                if (!rb_sts.pend_valid || rb_sts.can_flush)
                    st_next = rpsd_pkg::S_IDLE;
            end
            default:
                st_next = rpsd_pkg::S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        target_next  = target_reg;
        done_next    = done_reg;
        fbuf_next    = fbuf_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        vel_next     = vel_reg;
        synced_next  = synced_reg;
        run_next     = run_reg;
        ptag_next    = ptag_reg;
        corr_next    = corr_reg;
        eoi_next     = eoi_reg;
        bs_ctl       = '0;
        rb_ctl       = '0;
        push_res.kind       = rpsd_pkg::KIND_SAMPLE;
        push_res.sample     = '0;
        push_res.produced   = done_reg;
        push_res.error_code = rpsd_pkg::ERR_NONE;

        unique case (st_reg)
            rpsd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    bs_ctl.load = 1'b1;
                    eoi_next    = end_of_input;
                    if (phase_reg == rpsd_pkg::PH_HEADER)
                    begin
                        // count arrives low byte first
                        target_next  = {data_byte, target_reg[CW-1:8]};
                        hdr_idx_next = hdr_idx_reg + HW'(1);
                    end
                end
            end
            rpsd_pkg::S_HDRCHK:
            begin
                if (adv)
                begin
                    priority if (target_reg > max_reg)
                    begin
                        rb_ctl.push         = 1'b1;
                        push_res.kind       = rpsd_pkg::KIND_ERROR;
                        push_res.error_code = rpsd_pkg::ERR_CAPACITY;
                        phase_next          = rpsd_pkg::PH_DRAIN;
                    end
                    else if (target_reg == '0)
                    begin
                        rb_ctl.push   = 1'b1;
                        push_res.kind = rpsd_pkg::KIND_FINISHED;
                        phase_next    = rpsd_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        phase_next = rpsd_pkg::PH_TAG;
                    end
                end
            end
            rpsd_pkg::S_BITS:
            begin
                if (adv)
                begin
                    bs_ctl.shift = 1'b1;
                    fbuf_next    = fshift;
                    fill_next    = fill_reg + FW'(1);
                    if (fdone)
                    begin
                        fbuf_next = '0;
                        fill_next = '0;
                        unique case (phase_reg)
                            rpsd_pkg::PH_TAG:
                            begin
                                priority if (tagv == rpsd_pkg::TAG_SYNC)
                                    phase_next = rpsd_pkg::PH_SYNC_POS;
                                else if (!synced_reg)
                                begin
                                    rb_ctl.push         = 1'b1;
                                    push_res.kind       = rpsd_pkg::KIND_ERROR;
                                    push_res.error_code = rpsd_pkg::ERR_NO_SYNC;
                                    phase_next          = rpsd_pkg::PH_DRAIN;
                                end
                                else if (tagv == rpsd_pkg::TAG_VELOCITY)
                                    phase_next = rpsd_pkg::PH_VEL;
                                else
                                begin
                                    ptag_next  = tagv;
                                    phase_next = rpsd_pkg::PH_RUNLEN;
                                end
                            end
                            rpsd_pkg::PH_SYNC_POS:
                            begin
                                pos_next   = zz;
                                phase_next = rpsd_pkg::PH_SYNC_VEL;
                            end
                            rpsd_pkg::PH_SYNC_VEL:
                            begin
                                vel_next          = zz;
                                synced_next       = 1'b1;
                                done_next         = done_inc;
                                rb_ctl.push       = 1'b1;
                                push_res.sample   = pos_reg;
                                push_res.produced = done_inc;
                                // on a count match the finished step drains
                                if (!match_inc)
                                    phase_next = rpsd_pkg::PH_TAG;
                            end
                            rpsd_pkg::PH_VEL:
                            begin
                                vel_next   = zz;
                                phase_next = rpsd_pkg::PH_TAG;
                            end
                            rpsd_pkg::PH_RUNLEN:
                            begin
                                run_next = run_len_v;
                                priority if (run_over)
                                begin
                                    rb_ctl.push         = 1'b1;
                                    push_res.kind       = rpsd_pkg::KIND_ERROR;
                                    push_res.error_code = rpsd_pkg::ERR_RUN_PAST;
                                    phase_next          = rpsd_pkg::PH_DRAIN;
                                end
                                else if (ptag_reg == rpsd_pkg::TAG_PREDICT)
                                    phase_next = rpsd_pkg::PH_CORR;
                                else
                                    phase_next = rpsd_pkg::PH_RAW;
                            end
                            rpsd_pkg::PH_CORR:
                            begin
                                corr_next = zz;
                            end
                            rpsd_pkg::PH_RAW:
                            begin
                                pos_next          = zz;
                                done_next         = done_inc;
                                run_next          = run_reg - RW'(1);
                                rb_ctl.push       = 1'b1;
                                push_res.sample   = zz;
                                push_res.produced = done_inc;
                                if (!match_inc && run_reg == RW'(1))
                                    phase_next = rpsd_pkg::PH_TAG;
                            end
                            default:
                                phase_next = phase_reg;
                        endcase
                    end
                end
            end
            rpsd_pkg::S_RUN:
            begin
                // one predicted sample per cycle while there is room for the word
                if (adv)
                begin
                    pos_next          = sat_pv;
                    done_next         = done_inc;
                    run_next          = run_reg - RW'(1);
                    rb_ctl.push       = 1'b1;
                    push_res.sample   = sat_pv;
                    push_res.produced = done_inc;
                end
            end
            rpsd_pkg::S_CORR:
            begin
                if (adv)
                begin
                    pos_next = sat_pc;
                    run_next = '0;
                    priority if (done_reg == target_reg)
                    begin
                        rb_ctl.push   = 1'b1;
                        push_res.kind = rpsd_pkg::KIND_FINISHED;
                        phase_next    = rpsd_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        phase_next = rpsd_pkg::PH_TAG;
                    end
                end
            end
            rpsd_pkg::S_FIN:
            begin
                if (adv)
                begin
                    rb_ctl.push   = 1'b1;
                    push_res.kind = rpsd_pkg::KIND_FINISHED;
                    phase_next    = rpsd_pkg::PH_DRAIN;
                end
            end
            rpsd_pkg::S_END:
            begin
                if (adv && eoi_reg)
                begin
                    // packet ended before a finished or error word
                    if (phase_reg != rpsd_pkg::PH_DRAIN)
                    begin
                        rb_ctl.push         = 1'b1;
                        push_res.kind       = rpsd_pkg::KIND_ERROR;
                        push_res.error_code = rpsd_pkg::ERR_TRUNCATED;
                    end
                    // fresh packet state
                    phase_next   = rpsd_pkg::PH_HEADER;
                    hdr_idx_next = '0;
                    target_next  = '0;
                    done_next    = '0;
                    fbuf_next    = '0;
                    fill_next    = '0;
                    pos_next     = '0;
                    vel_next     = '0;
                    synced_next  = 1'b0;
                    run_next     = '0;
                    ptag_next    = '0;
                end
            end
            rpsd_pkg::S_FLUSH:
            begin
                // held word is the last of this byte
                rb_ctl.flush = rb_sts.pend_valid && rb_sts.can_flush;
            end
            default:
                rb_ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= rpsd_pkg::S_IDLE;
            phase_reg   <= rpsd_pkg::PH_HEADER;
            hdr_idx_reg <= '0;
            target_reg  <= '0;
            done_reg    <= '0;
            fbuf_reg    <= '0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            vel_reg     <= '0;
            synced_reg  <= 1'b0;
            run_reg     <= '0;
            ptag_reg    <= '0;
            eoi_reg     <= 1'b0;
            max_reg     <= '1;
        end
        else
        begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            target_reg  <= target_next;
            done_reg    <= done_next;
            fbuf_reg    <= fbuf_next;
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            vel_reg     <= vel_next;
            synced_reg  <= synced_next;
            run_reg     <= run_next;
            ptag_reg    <= ptag_next;
            eoi_reg     <= eoi_next;
            if (cfg_wen)
                max_reg <= cfg_wdata;
        end
    end

    // correction is payload, loaded before use
    always_ff @(posedge clk)
    begin
        corr_reg <= corr_next;
    end

    `RPSD_ASSERT_NOW(a_ready_no_held, in_ready, !rb_sts.pend_valid,
                     "ready with a held word")
    `RPSD_ASSERT_NOW(a_run_nonzero, st_reg == rpsd_pkg::S_RUN, run_reg != '0,
                     "predict run with zero length")
    `RPSD_ASSERT_NOW(a_done_bound, phase_reg != rpsd_pkg::PH_HEADER, done_reg <= target_reg,
                     "sample count past target")
    `RPSD_ASSERT_NEXT(a_accept_busy, accept, !in_ready, "ready right after accept")

endmodule
`default_nettype wire

FILE: sim/rpsd_decode_checker.sv
// checker for the run prediction sample decoder: predicts every output word and compares
`timescale 1ns / 1ps
module rpsd_decode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_input,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         kind,
    input  logic signed [15:0] sample,
    input  logic [31:0]        produced,
    input  logic [2:0]         error_code,
    input  logic               final_res,
    output int                 mismatches,
    output int                 words_owed
);

    typedef struct {
        rpsd_pkg::kind_t kind;
        logic [15:0]     sample;
        logic [31:0]     produced;
        rpsd_pkg::err_t  code;
        logic            last;
    } word_t;

    word_t       expected_words[$];
    word_t       held;
    bit          have_held;

    logic [31:0]       max_cap;
    rpsd_pkg::phase_t  ph;
    logic [1:0]        hdr_idx;
    logic [31:0]       target_cnt;
    logic [31:0]       done_cnt;
    logic [15:0]       field;
    int                fill;
    logic [15:0]       pos;
    logic [15:0]       vel;
    bit                synced;
    int                run_left;
    logic [1:0]        tag_hold;

    function automatic logic [15:0] zz_decode(input logic [15:0] u);
        return {1'b0, u[15:1]} ^ {16{u[0]}};
    endfunction

    function automatic logic [15:0] clamp_sum(input logic [15:0] a, input logic [15:0] b);
        int s;
        s = int'($signed(a)) + int'($signed(b));
        if (s > 32767)
        begin
            s = 32767;
        end
        if (s < -32768)
        begin
            s = -32768;
        end
        return s[15:0];
    endfunction

    task automatic begin_packet();
        ph         = rpsd_pkg::PH_HEADER;
        hdr_idx    = '0;
        target_cnt = '0;
        done_cnt   = '0;
        field      = '0;
        fill       = 0;
        pos        = '0;
        vel        = '0;
        synced     = 1'b0;
        run_left   = 0;
        tag_hold   = '0;
    endtask

    // the previous word is pushed only once a later one exists, so the last one can be flagged
    task automatic post_word(input rpsd_pkg::kind_t k, input logic [15:0] s,
                             input rpsd_pkg::err_t e);
        if (have_held)
        begin
            expected_words.push_back(held);
        end
        held.kind     = k;
        held.sample   = s;
        held.produced = done_cnt;
        held.code     = e;
        held.last     = 1'b0;
        have_held     = 1'b1;
    endtask

    task automatic abort_packet(input rpsd_pkg::err_t e);
        post_word(rpsd_pkg::KIND_ERROR, '0, e);
        ph = rpsd_pkg::PH_DRAIN;
    endtask

    task automatic next_field(input rpsd_pkg::phase_t p);
        ph    = p;
        field = '0;
        fill  = 0;
    endtask

    task automatic close_samples();
        if (done_cnt == target_cnt)
        begin
            post_word(rpsd_pkg::KIND_FINISHED, '0, rpsd_pkg::ERR_NONE);
            ph = rpsd_pkg::PH_DRAIN;
        end
        else
        begin
            next_field(rpsd_pkg::PH_TAG);
        end
    endtask

    task automatic take_bit(input logic b);
        int          need;
        int          k;
        logic [15:0] v;
        need = 16;
        if (ph == rpsd_pkg::PH_TAG)
        begin
            need = rpsd_pkg::TAG_BITS;
        end
        else if (ph == rpsd_pkg::PH_RUNLEN)
        begin
            need = rpsd_pkg::RUN_FIELD_BITS;
        end
        field[fill] = b;
        fill++;
        if (fill < need)
        begin
            return;
        end
        v = field;
        case (ph)
            rpsd_pkg::PH_TAG:
            begin
                if (v[1:0] == rpsd_pkg::TAG_SYNC)
                begin
                    next_field(rpsd_pkg::PH_SYNC_POS);
                end
                else if (!synced)
                begin
                    abort_packet(rpsd_pkg::ERR_NO_SYNC);
                end
                else if (v[1:0] == rpsd_pkg::TAG_VELOCITY)
                begin
                    next_field(rpsd_pkg::PH_VEL);
                end
                else
                begin
                    tag_hold = v[1:0];
                    next_field(rpsd_pkg::PH_RUNLEN);
                end
            end
            rpsd_pkg::PH_SYNC_POS:
            begin
                pos = zz_decode(v);
                next_field(rpsd_pkg::PH_SYNC_VEL);
            end
            rpsd_pkg::PH_SYNC_VEL:
            begin
                vel    = zz_decode(v);
                synced = 1'b1;
                done_cnt++;
                post_word(rpsd_pkg::KIND_SAMPLE, pos, rpsd_pkg::ERR_NONE);
                close_samples();
            end
            rpsd_pkg::PH_VEL:
            begin
                vel = zz_decode(v);
                next_field(rpsd_pkg::PH_TAG);
            end
            rpsd_pkg::PH_RUNLEN:
            begin
                run_left = int'(v[rpsd_pkg::RUN_FIELD_BITS-1:0]) + 1;
                if ({1'b0, done_cnt} + 33'(run_left) > {1'b0, target_cnt})
                begin
                    abort_packet(rpsd_pkg::ERR_RUN_PAST);
                end
                else if (tag_hold == rpsd_pkg::TAG_PREDICT)
                begin
                    next_field(rpsd_pkg::PH_CORR);
                end
                else
                begin
                    next_field(rpsd_pkg::PH_RAW);
                end
            end
            rpsd_pkg::PH_CORR:
            begin
                for (k = 0; k < run_left; k++)
                begin
                    pos = clamp_sum(pos, vel);
                    done_cnt++;
                    post_word(rpsd_pkg::KIND_SAMPLE, pos, rpsd_pkg::ERR_NONE);
                end
                pos      = clamp_sum(pos, zz_decode(v));
                run_left = 0;
                close_samples();
            end
            rpsd_pkg::PH_RAW:
            begin
                pos = zz_decode(v);
                done_cnt++;
                post_word(rpsd_pkg::KIND_SAMPLE, pos, rpsd_pkg::ERR_NONE);
                if (run_left > 0)
                begin
                    run_left--;
                end
                if (done_cnt == target_cnt)
                begin
                    post_word(rpsd_pkg::KIND_FINISHED, '0, rpsd_pkg::ERR_NONE);
                    ph = rpsd_pkg::PH_DRAIN;
                end
                else if (run_left == 0)
                begin
                    next_field(rpsd_pkg::PH_TAG);
                end
                else
                begin
                    next_field(rpsd_pkg::PH_RAW);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eoi);
        int sh;
        int i;
        if (ph == rpsd_pkg::PH_HEADER)
        begin
            sh         = 8 * int'(hdr_idx);
            target_cnt = target_cnt | (32'(b) << sh);
            hdr_idx++;
            if (hdr_idx == 2'd0)
            begin
                if (target_cnt > max_cap)
                begin
                    abort_packet(rpsd_pkg::ERR_CAPACITY);
                end
                else if (target_cnt == 32'd0)
                begin
                    post_word(rpsd_pkg::KIND_FINISHED, '0, rpsd_pkg::ERR_NONE);
                    ph = rpsd_pkg::PH_DRAIN;
                end
                else
                begin
                    next_field(rpsd_pkg::PH_TAG);
                end
            end
        end
        else
        begin
            for (i = 0; i < 8; i++)
            begin
                if (ph != rpsd_pkg::PH_DRAIN)
                begin
                    take_bit(b[i]);
                end
            end
        end
        if (eoi)
        begin
            if (ph != rpsd_pkg::PH_DRAIN)
            begin
                abort_packet(rpsd_pkg::ERR_TRUNCATED);
            end
            begin_packet();
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_words.push_back(held);
            have_held = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            begin_packet();
            max_cap = '1;
            expected_words.delete();
            have_held  = 1'b0;
            mismatches = 0;
            words_owed = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                max_cap = cfg_wdata;
            end
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, end_of_input);
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no word, got kind %0h sample %0h produced %0h code %0h",
                             $time, kind, sample, produced, error_code);
                end
                else
                begin
                    w = expected_words.pop_front();
                    check_field("kind", 32'(w.kind), 32'(kind));
                    check_field("sample", 32'(w.sample), 32'($unsigned(sample)));
                    check_field("produced", w.produced, produced);
                    check_field("error_code", 32'(w.code), 32'(error_code));
                    check_field("final_res", 32'(w.last), 32'(final_res));
                end
            end
            words_owed = expected_words.size();
        end
    end

endmodule

FILE: sim/tb_run_prediction_sample_decoder_unit.sv
// testbench top for the run prediction sample decoder: packet stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_run_prediction_sample_decoder_unit;

    // cycles with no word moving on either channel before the run is called hung
    localparam int STALL_LIMIT = 4000;
    // quiet cycles after the last expected word, covers a stream byte plus a full predict run
    localparam int DRAIN_CYCLES = 64;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               end_of_input;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [31:0]        produced;
    logic [2:0]         error_code;
    logic               final_res;

    int                 mismatches;
    int                 words_owed;

    // idling percentages of the current phase
    int                 in_idle_pct;
    int                 out_stall_pct;

    // packet under construction: whole bytes, then the token bit stream lsb first
    logic [7:0]         pkt_bytes[$];
    bit                 stream_bits[$];
    int                 bytes_sent;
    int                 quiet_cycles;

    int                 phase_idx;
    int                 phase_start;
    int                 phase_budget;
    logic [31:0]        cap_value;

    run_prediction_sample_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .sample       (sample),
        .produced     (produced),
        .error_code   (error_code),
        .final_res    (final_res)
    );

    rpsd_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .sample       (sample),
        .produced     (produced),
        .error_code   (error_code),
        .final_res    (final_res),
        .mismatches   (mismatches),
        .words_owed   (words_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // receiver side: ready changes on the falling edge only
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // watchdog: restarts whenever a word moves on either channel
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // 16-bit zigzag code, biased toward the codes of the sample extremes
    function automatic logic [15:0] pick_zz16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;   // -32768
            2: return 16'hFFFE;   // 32767
            3: return 16'h0001;   // -1
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put_field(input logic [31:0] value, input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            stream_bits.push_back(value[i]);
        end
    endtask

    task automatic put_header(input logic [31:0] count);
        int i;
        for (i = 0; i < 4; i++)
        begin
            pkt_bytes.push_back(count[8*i +: 8]);
        end
    endtask

    task automatic put_sync(input logic [15:0] pos_zz, input logic [15:0] vel_zz);
        put_field(32'(rpsd_pkg::TAG_SYNC), rpsd_pkg::TAG_BITS);
        put_field(32'(pos_zz), 16);
        put_field(32'(vel_zz), 16);
    endtask

    task automatic put_velocity(input logic [15:0] vel_zz);
        put_field(32'(rpsd_pkg::TAG_VELOCITY), rpsd_pkg::TAG_BITS);
        put_field(32'(vel_zz), 16);
    endtask

    // run tag plus the length field, which carries the length minus one
    task automatic put_run(input logic [1:0] tag, input int len);
        put_field(32'(tag), rpsd_pkg::TAG_BITS);
        put_field(32'(len - 1), rpsd_pkg::RUN_FIELD_BITS);
    endtask

    // pad the bit stream to a byte boundary with random bits and append it
    task automatic pack_bits();
        logic [7:0] b;
        int         i;
        while (stream_bits.size() % 8 != 0)
        begin
            stream_bits.push_back(bit'($urandom_range(0, 1)));
        end
        while (stream_bits.size() > 0)
        begin
            for (i = 0; i < 8; i++)
            begin
                b[i] = stream_bits.pop_front();
            end
            pkt_bytes.push_back(b);
        end
    endtask

    // one input word: optional idle gap, then hold valid until accepted
    task automatic send_word(input logic [7:0] b, input logic eoi);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < in_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // the packet's last byte carries end of input
    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
        begin
            send_word(pkt_bytes[i], (i == pkt_bytes.size() - 1));
        end
        bytes_sent += pkt_bytes.size();
        pkt_bytes.delete();
    endtask

    // mostly well-formed packets with random content, some broken ones and noise
    task automatic build_random_packet();
        int     r;
        int     k;
        int     tokens;
        int     len;
        int     room;
        int     lim;
        int     cut;
        longint count;
        longint done;
        bit     broken;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            // header cut short
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        k = $urandom_range(0, 99);
        if (k < 5)
        begin
            count = 0;
        end
        else if (k < 10)
        begin
            count = longint'($urandom);
        end
        else if (k < 18)
        begin
            count = $urandom_range(41, 70);
        end
        else
        begin
            count = $urandom_range(1, 40);
        end
        put_header(count[31:0]);
        if (r < 12)
        begin
            // noise after a header
            repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        broken = 1'b0;
        tokens = 0;
        done   = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            // token ahead of any sync
            put_field($urandom_range(1, 3), rpsd_pkg::TAG_BITS);
            broken = 1'b1;
        end
        else
        begin
            put_sync(pick_zz16(), pick_zz16());
            done = 1;
        end
        while (!broken && done < count && tokens < 14)
        begin
            tokens++;
            r    = $urandom_range(0, 99);
            room = (count - done > 32) ? 32 : int'(count - done);
            if (r < 12)
            begin
                put_sync(pick_zz16(), pick_zz16());
                done++;
            end
            else if (r < 27)
            begin
                put_velocity(pick_zz16());
            end
            else if (r < 70)
            begin
                len = $urandom_range(1, room);
                if ($urandom_range(0, 19) == 0)
                begin
                    len    = $urandom_range(1, 32);
                    broken = (done + len > count);
                end
                put_run(rpsd_pkg::TAG_PREDICT, len);
                put_field(32'(pick_zz16()), 16);
                done += len;
            end
            else
            begin
                lim = (room > 4) ? 4 : room;
                len = $urandom_range(1, lim);
                if ($urandom_range(0, 19) == 0)
                begin
                    len    = $urandom_range(1, 32);
                    broken = (done + len > count);
                end
                put_run(rpsd_pkg::TAG_RAW, len);
                if (!broken)
                begin
                    for (k = 0; k < len; k++)
                    begin
                        put_field(32'(pick_zz16()), 16);
                    end
                end
                done += len;
            end
        end
        pack_bits();
        // trailing bytes after the count is reached are ignored by the block
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
        end
        // early end of input
        if ($urandom_range(0, 9) == 0 && pkt_bytes.size() > 1)
        begin
            cut = $urandom_range(1, pkt_bytes.size() - 1);
            repeat (cut) void'(pkt_bytes.pop_back());
        end
    endtask

    // wait until every expected word is out, then let the block run dry
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cap(input logic [31:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin
        // every input known from time zero
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_input  = 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        bytes_sent    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, capacity at its reset value
        // zero count: finished right after the header
        put_header(32'd0);
        send_packet();
        // header cut short by end of input
        pkt_bytes.push_back(8'h07);
        pkt_bytes.push_back(8'h00);
        send_packet();
        // velocity token ahead of any sync
        put_header(32'd1);
        put_velocity(16'h1234);
        pack_bits();
        send_packet();
        // every token, saturation both ways, a full-length predict run, count reached
        put_header(32'd35);
        put_sync(16'hFFFE, 16'hFFFE);
        put_run(rpsd_pkg::TAG_PREDICT, 1);
        put_field(32'h0000_FFFF, 16);
        put_velocity(16'hFFFF);
        put_run(rpsd_pkg::TAG_PREDICT, 32);
        put_field(32'h0000_0000, 16);
        put_run(rpsd_pkg::TAG_RAW, 1);
        put_field(32'h0000_0001, 16);
        pack_bits();
        send_packet();
        // raw run past the count
        put_header(32'd2);
        put_sync(16'h0000, 16'h0000);
        put_run(rpsd_pkg::TAG_RAW, 2);
        pack_bits();
        send_packet();

        // random phases: capacity setting and idling pattern change between them
        for (phase_idx = 0; phase_idx < 5; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    cap_value = 32'hFFFF_FFFF;
                    phase_budget = 20;
                end
                1:
                begin
                    cap_value = 32'h0000_0000;
                    phase_budget = 8;
                end
                2:
                begin
                    cap_value = 32'd40;
                    phase_budget = 20;
                end
                3:
                begin
                    cap_value = 32'd25;
                    phase_budget = 20;
                end
                default:
                begin
                    cap_value = 32'hFFFF_FFFF;
                    phase_budget = 20;
                end
            endcase
            settle();
            write_cap(cap_value);
            case (phase_idx)
                0:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1, 2:
                begin
                    in_idle_pct = 60;
                    out_stall_pct = 0;
                end
                3:
                begin
                    in_idle_pct = 0;
                    out_stall_pct = 60;
                end
                default:
                begin
                    in_idle_pct = 35;
                    out_stall_pct = 35;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_budget)
            begin
                build_random_packet();
                send_packet();
            end
        end

        settle();
        if (mismatches == 0 && words_owed == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
